// ===== hdl/ffa_pkg.sv =====
// shared types, codes and default sizes for the first-fit free-list allocator
// no dependencies; imported by ffa_hdr_store, first_fit_free_list_allocator and the testbench
`default_nettype none

package ffa_pkg;

    // default arena geometry
    localparam int ARENA_BYTES_DEF  = 4096;
    localparam int HEADER_BYTES_DEF = 16;

    // fixed field widths
    localparam int OP_W     = 2;
    localparam int REQ_W    = 13;
    localparam int REL_W    = 12;
    localparam int STATUS_W = 3;
    localparam int VAL_W    = 13;

    localparam logic [VAL_W-1:0] SUM_MAX = 13'd8191;

    // opcodes
    localparam logic [OP_W-1:0] OP_ALLOC = 2'd0;
    localparam logic [OP_W-1:0] OP_FREE  = 2'd1;
    localparam logic [OP_W-1:0] OP_QUERY = 2'd2;
    localparam logic [OP_W-1:0] OP_NONE  = 2'd3;

    // result status codes
    localparam logic [STATUS_W-1:0] STS_ALLOC     = 3'd0;
    localparam logic [STATUS_W-1:0] STS_ZERO      = 3'd1;
    localparam logic [STATUS_W-1:0] STS_NO_FIT    = 3'd2;
    localparam logic [STATUS_W-1:0] STS_FREED     = 3'd3;
    localparam logic [STATUS_W-1:0] STS_NULL_FREE = 3'd4;
    localparam logic [STATUS_W-1:0] STS_QUERY     = 3'd5;

    // sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_INIT,
        ST_START,
        ST_WALK,
        ST_FIT,
        ST_TAIL1,
        ST_TAIL2,
        ST_TAIL3,
        ST_WR_TAIL,
        ST_WR_PREV,
        ST_WR_CUR,
        ST_FREE,
        ST_RESP
    } ffa_state_t;

    // header store port controls
    typedef struct packed {
        logic rd_en;
        logic size_we;
        logic link_we;
    } hdr_ctrl_t;

endpackage

`default_nettype wire

// ===== hdl/first_fit_free_list_allocator.sv =====
// top level of the first-fit free-list allocator: sequencer, shared adder, result register
// depends on ffa_pkg and ffa_hdr_store
`default_nettype none

// First-fit allocator over an arena of ARENA_BYTES bytes with HEADER_BYTES-byte block
// headers kept in an on-chip header store. One transaction at a time: in_ready is high only
// while the sequencer is idle, and a finished result sits in the output register until taken.
// A free passes through the free state to the response state, and a zero-size allocate goes
// straight to the response state; the unused opcode is dropped in its accepting cycle. A query
// walks the list and then responds. An allocate walks to the first fit, then, if the block is
// split, works out and writes the tail header, then relinks the list and responds; the very
// first allocate lays out the arena before its walk. A stalled output holds the sequencer in
// its response state. The walk rate is one header per cycle, set by the single read port of
// the header store, and the arithmetic (fit compare, remainder, tail address, wrap, payload
// offset, free sum) goes through one shared adder. A walk stops after ARENA_BYTES headers, so
// a cyclic list cannot hang the block. The header store needs no clearing pass after reset.
module first_fit_free_list_allocator #(
    parameter int ARENA_BYTES  = ffa_pkg::ARENA_BYTES_DEF,
    parameter int HEADER_BYTES = ffa_pkg::HEADER_BYTES_DEF
) (
    input  wire                          clk,
    input  wire                          rst_n,
    input  wire                          in_valid,
    output logic                         in_ready,
    input  wire [ffa_pkg::OP_W-1:0]      opcode,
    input  wire [ffa_pkg::REQ_W-1:0]     request_bytes,
    input  wire [ffa_pkg::REL_W-1:0]     release_offset,
    output logic                         out_valid,
    input  wire                          out_ready,
    output logic [ffa_pkg::STATUS_W-1:0] status,
    output logic [ffa_pkg::VAL_W-1:0]    result_value
);
    import ffa_pkg::*;

    localparam int ADDR_W = $clog2(ARENA_BYTES);
    localparam int LINK_W = $clog2(ARENA_BYTES + 1);
    // adder width: covers links, request sizes and offsets plus one guard bit
    localparam int CW     = ((LINK_W > REQ_W) ? LINK_W : REQ_W) + 1;

    localparam logic [LINK_W-1:0] NULL_LINK = LINK_W'(ARENA_BYTES);
    localparam logic [CW-1:0]     ARENA_C   = CW'(ARENA_BYTES);
    localparam logic [CW-1:0]     HDR_C     = CW'(HEADER_BYTES);
    localparam logic [ADDR_W-1:0] INIT_SIZE = ADDR_W'(ARENA_BYTES - HEADER_BYTES);
    localparam logic [LINK_W-1:0] LAST_STEP = LINK_W'(ARENA_BYTES - 1);

    // sequencer and control state
    ffa_state_t state_reg, state_next;
    logic       arena_ready_reg, arena_ready_next;
    logic [LINK_W-1:0] head_reg, head_next;
    logic       out_valid_reg, out_valid_next;

    // transaction and walk payload
    logic [OP_W-1:0]     op_reg, op_next;
    logic [REQ_W-1:0]    req_reg, req_next;
    logic [REL_W-1:0]    rel_reg, rel_next;
    logic [ADDR_W-1:0]   cur_reg, cur_next;
    logic [LINK_W-1:0]   prev_reg, prev_next;
    logic [LINK_W-1:0]   link_c_reg, link_c_next;
    logic [ADDR_W-1:0]   rem_reg, rem_next;
    logic [CW-1:0]       tmp_reg, tmp_next;
    logic                split_reg, split_next;
    logic [LINK_W-1:0]   steps_reg, steps_next;
    logic [VAL_W-1:0]    sum_reg, sum_next;
    logic [STATUS_W-1:0] resp_status_reg, resp_status_next;
    logic [VAL_W-1:0]    resp_value_reg, resp_value_next;
    logic [STATUS_W-1:0] out_status_reg, out_status_next;
    logic [VAL_W-1:0]    out_value_reg, out_value_next;

    // header store interface
    hdr_ctrl_t         ctrl;
    logic [ADDR_W-1:0] rd_addr;
    logic [ADDR_W-1:0] size_waddr;
    logic [ADDR_W-1:0] size_wdata;
    logic [ADDR_W-1:0] link_waddr;
    logic [LINK_W-1:0] link_wdata;
    logic [ADDR_W-1:0] rd_size;
    logic [LINK_W-1:0] rd_link;

    // shared adder: a + b, or a - b with carry meaning a >= b
    logic [CW-1:0] alu_a, alu_b, alu_res;
    logic          alu_sub, alu_carry;
    logic [CW:0]   alu_sum;

    // helpers
    logic              walk_end;
    logic              fit_split;
    logic [VAL_W-1:0]  sum_sat;
    logic [LINK_W-1:0] new_link;

    assign alu_sum   = {1'b0, alu_a} + {1'b0, (alu_sub ? ~alu_b : alu_b)} + (CW+1)'(alu_sub);
    assign alu_res   = alu_sum[CW-1:0];
    assign alu_carry = alu_sum[CW];

    // last header of a walk: end of list, or the visit limit reached
    assign walk_end  = (rd_link == NULL_LINK) || (steps_reg == LAST_STEP);
    assign fit_split = alu_carry && (alu_res != '0);
    assign sum_sat   = (alu_res > CW'(SUM_MAX)) ? SUM_MAX : alu_res[VAL_W-1:0];
    assign new_link  = split_reg ? LINK_W'(tmp_reg[ADDR_W-1:0]) : link_c_reg;

    assign in_ready     = (state_reg == ST_IDLE);
    assign out_valid    = out_valid_reg;
    assign status       = out_status_reg;
    assign result_value = out_value_reg;

    ffa_hdr_store #(
        .ARENA_BYTES (ARENA_BYTES)
    ) u_hdr_store (
        .clk        (clk),
        .ctrl       (ctrl),
        .rd_addr    (rd_addr),
        .size_waddr (size_waddr),
        .size_wdata (size_wdata),
        .link_waddr (link_waddr),
        .link_wdata (link_wdata),
        .rd_size    (rd_size),
        .rd_link    (rd_link)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    case (opcode)
                        OP_ALLOC:
                        begin
                            if (request_bytes == '0)
                            begin
                                state_next = ST_RESP;
                            end
                            else if (arena_ready_reg)
                            begin
                                state_next = ST_START;
                            end
                            else
                            begin
                                state_next = ST_INIT;
                            end
                        end
                        OP_FREE:  state_next = ST_FREE;
                        OP_QUERY: state_next = ST_START;
                        default:  state_next = ST_IDLE;
                    endcase
                end
            end
            ST_INIT:    state_next = ST_START;
            ST_START:   state_next = (head_reg == NULL_LINK) ? ST_RESP : ST_WALK;
            ST_WALK:
            begin
                if ((op_reg == OP_ALLOC) && alu_carry)
                begin
                    state_next = ST_FIT;
                end
                else if (walk_end)
                begin
                    state_next = ST_RESP;
                end
            end
            ST_FIT:     state_next = fit_split ? ST_TAIL1 : ST_WR_PREV;
            ST_TAIL1:   state_next = ST_TAIL2;
            ST_TAIL2:   state_next = ST_TAIL3;
            ST_TAIL3:   state_next = ST_WR_TAIL;
            ST_WR_TAIL: state_next = ST_WR_PREV;
            ST_WR_PREV: state_next = ST_WR_CUR;
            ST_WR_CUR:  state_next = ST_RESP;
            ST_FREE:    state_next = ST_RESP;
            ST_RESP:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:    state_next = ST_IDLE;
        endcase
    end

    // datapath, adder operands and header store controls
    always_comb
    begin
        arena_ready_next = arena_ready_reg;
        head_next        = head_reg;
        out_valid_next   = out_valid_reg && !out_ready;
        op_next          = op_reg;
        req_next         = req_reg;
        rel_next         = rel_reg;
        cur_next         = cur_reg;
        prev_next        = prev_reg;
        link_c_next      = link_c_reg;
        rem_next         = rem_reg;
        tmp_next         = tmp_reg;
        split_next       = split_reg;
        steps_next       = steps_reg;
        sum_next         = sum_reg;
        resp_status_next = resp_status_reg;
        resp_value_next  = resp_value_reg;
        out_status_next  = out_status_reg;
        out_value_next   = out_value_reg;

        ctrl       = '0;
        rd_addr    = '0;
        size_waddr = '0;
        size_wdata = '0;
        link_waddr = '0;
        link_wdata = '0;

        alu_a   = '0;
        alu_b   = '0;
        alu_sub = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    op_next          = opcode;
                    req_next         = request_bytes;
                    rel_next         = release_offset;
                    resp_status_next = STS_ZERO;
                    resp_value_next  = '0;
                end
            end
            ST_INIT:
            begin
                // whole arena as one free block at offset zero
                ctrl.size_we     = 1'b1;
                ctrl.link_we     = 1'b1;
                size_waddr       = '0;
                size_wdata       = INIT_SIZE;
                link_waddr       = '0;
                link_wdata       = NULL_LINK;
                head_next        = '0;
                arena_ready_next = 1'b1;
            end
            ST_START:
            begin
                prev_next  = NULL_LINK;
                cur_next   = head_reg[ADDR_W-1:0];
                steps_next = '0;
                sum_next   = '0;
                resp_value_next  = '0;
                resp_status_next = (op_reg == OP_ALLOC) ? STS_NO_FIT : STS_QUERY;
                if (head_reg != NULL_LINK)
                begin
                    ctrl.rd_en = 1'b1;
                    rd_addr    = head_reg[ADDR_W-1:0];
                end
            end
            ST_WALK:
            begin
                if (op_reg == OP_ALLOC)
                begin
                    alu_a   = CW'(rd_size);
                    alu_b   = CW'(req_reg);
                    alu_sub = 1'b1;
                end
                else
                begin
                    alu_a   = CW'(sum_reg);
                    alu_b   = CW'(rd_size);
                    alu_sub = 1'b0;
                end

                if ((op_reg == OP_ALLOC) && alu_carry)
                begin
                    // first fit found: keep remainder and successor
                    rem_next    = alu_res[ADDR_W-1:0];
                    link_c_next = rd_link;
                end
                else
                begin
                    if (op_reg != OP_ALLOC)
                    begin
                        sum_next = sum_sat;
                    end
                    prev_next  = LINK_W'(cur_reg);
                    steps_next = steps_reg + LINK_W'(1);
                    if (walk_end)
                    begin
                        resp_status_next = (op_reg == OP_ALLOC) ? STS_NO_FIT : STS_QUERY;
                        resp_value_next  = (op_reg == OP_ALLOC) ? '0 : sum_sat;
                    end
                    else
                    begin
                        ctrl.rd_en = 1'b1;
                        rd_addr    = rd_link[ADDR_W-1:0];
                        cur_next   = rd_link[ADDR_W-1:0];
                    end
                end
            end
            ST_FIT:
            begin
                // split only when the remainder exceeds one header
                alu_a      = CW'(rem_reg);
                alu_b      = HDR_C;
                alu_sub    = 1'b1;
                split_next = fit_split;
                rem_next   = alu_res[ADDR_W-1:0];
            end
            ST_TAIL1:
            begin
                alu_a    = CW'(cur_reg);
                alu_b    = CW'(req_reg);
                tmp_next = alu_res;
            end
            ST_TAIL2:
            begin
                alu_a    = tmp_reg;
                alu_b    = HDR_C;
                tmp_next = alu_res;
            end
            ST_TAIL3:
            begin
                // tail offset wraps around the arena end
                alu_a   = tmp_reg;
                alu_b   = ARENA_C;
                alu_sub = 1'b1;
                if (alu_carry)
                begin
                    tmp_next = alu_res;
                end
            end
            ST_WR_TAIL:
            begin
                ctrl.size_we = 1'b1;
                ctrl.link_we = 1'b1;
                size_waddr   = tmp_reg[ADDR_W-1:0];
                size_wdata   = rem_reg;
                link_waddr   = tmp_reg[ADDR_W-1:0];
                link_wdata   = link_c_reg;
            end
            ST_WR_PREV:
            begin
                if (split_reg)
                begin
                    ctrl.size_we = 1'b1;
                    size_waddr   = cur_reg;
                    size_wdata   = ADDR_W'(req_reg);
                end
                if (prev_reg == NULL_LINK)
                begin
                    head_next = new_link;
                end
                else
                begin
                    ctrl.link_we = 1'b1;
                    link_waddr   = prev_reg[ADDR_W-1:0];
                    link_wdata   = new_link;
                end
            end
            ST_WR_CUR:
            begin
                ctrl.link_we     = 1'b1;
                link_waddr       = cur_reg;
                link_wdata       = NULL_LINK;
                alu_a            = CW'(cur_reg);
                alu_b            = HDR_C;
                resp_status_next = STS_ALLOC;
                resp_value_next  = alu_res[VAL_W-1:0];
            end
            ST_FREE:
            begin
                // header offset must lie inside the arena
                alu_a           = CW'(rel_reg);
                alu_b           = HDR_C;
                alu_sub         = 1'b1;
                resp_value_next = '0;
                if (alu_carry && (alu_res < ARENA_C))
                begin
                    ctrl.link_we     = 1'b1;
                    link_waddr       = alu_res[ADDR_W-1:0];
                    link_wdata       = head_reg;
                    head_next        = alu_res[LINK_W-1:0];
                    resp_status_next = STS_FREED;
                end
                else
                begin
                    resp_status_next = STS_NULL_FREE;
                end
            end
            ST_RESP:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = resp_status_reg;
                    out_value_next  = resp_value_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            arena_ready_reg <= 1'b0;
            head_reg        <= NULL_LINK;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            arena_ready_reg <= arena_ready_next;
            head_reg        <= head_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        op_reg          <= op_next;
        req_reg         <= req_next;
        rel_reg         <= rel_next;
        cur_reg         <= cur_next;
        prev_reg        <= prev_next;
        link_c_reg      <= link_c_next;
        rem_reg         <= rem_next;
        tmp_reg         <= tmp_next;
        split_reg       <= split_next;
        steps_reg       <= steps_next;
        sum_reg         <= sum_next;
        resp_status_reg <= resp_status_next;
        resp_value_reg  <= resp_value_next;
        out_status_reg  <= out_status_next;
        out_value_reg   <= out_value_next;
    end

    // the list is only read while walking, never written
    a_no_write_in_walk: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WALK) |-> !(ctrl.size_we || ctrl.link_we))
        else $error("header store written during a list walk");

    // a result only appears out of the response state
    a_result_from_resp: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) == ST_RESP))
        else $error("result register loaded outside the response state");

    // a real transaction blocks the input until its result is formed
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && (opcode != OP_NONE)) |=> !in_ready)
        else $error("input accepted again while a transaction is in progress");

    // list head is either a header offset inside the arena or the null link
    a_head_range: assert property (@(posedge clk) disable iff (!rst_n)
        head_reg <= NULL_LINK)
        else $error("list head outside the arena");

endmodule

`default_nettype wire

// ===== hdl/ffa_hdr_store.sv =====
// header store: block size and next-link arrays, one read and one write port each
// depends on ffa_pkg (hdr_ctrl_t)
`default_nettype none

module ffa_hdr_store #(
    parameter int ARENA_BYTES = ffa_pkg::ARENA_BYTES_DEF
) (
    input  wire                               clk,
    input  ffa_pkg::hdr_ctrl_t                ctrl,
    input  wire [$clog2(ARENA_BYTES)-1:0]     rd_addr,
    input  wire [$clog2(ARENA_BYTES)-1:0]     size_waddr,
    input  wire [$clog2(ARENA_BYTES)-1:0]     size_wdata,
    input  wire [$clog2(ARENA_BYTES)-1:0]     link_waddr,
    input  wire [$clog2(ARENA_BYTES+1)-1:0]   link_wdata,
    output logic [$clog2(ARENA_BYTES)-1:0]    rd_size,
    output logic [$clog2(ARENA_BYTES+1)-1:0]  rd_link
);
    import ffa_pkg::*;

    localparam int ADDR_W = $clog2(ARENA_BYTES);
    localparam int LINK_W = $clog2(ARENA_BYTES + 1);

    logic [ADDR_W-1:0] size_mem [ARENA_BYTES];
    logic [LINK_W-1:0] link_mem [ARENA_BYTES];

    // contents undefined until written, so no reset or clearing
    always_ff @(posedge clk)
    begin
        if (ctrl.size_we)
        begin
            size_mem[size_waddr] <= size_wdata;
        end
        if (ctrl.link_we)
        begin
            link_mem[link_waddr] <= link_wdata;
        end
        if (ctrl.rd_en)
        begin
            rd_size <= size_mem[rd_addr];
            rd_link <= link_mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ===== tb/sv/ffa_result_checker.sv =====
`timescale 1ns / 1ps
// result checker for the first-fit free-list allocator: mirrors the free list and scores results
// depends on ffa_pkg for field widths, opcodes and status codes
module ffa_result_checker #(
    parameter int ARENA_BYTES  = ffa_pkg::ARENA_BYTES_DEF,
    parameter int HEADER_BYTES = ffa_pkg::HEADER_BYTES_DEF
) (
    input  wire                         clk,
    input  wire                         rst_n,
    input  wire                         in_valid,
    input  wire                         in_ready,
    input  wire [ffa_pkg::OP_W-1:0]     opcode,
    input  wire [ffa_pkg::REQ_W-1:0]    request_bytes,
    input  wire [ffa_pkg::REL_W-1:0]    release_offset,
    input  wire                         out_valid,
    input  wire                         out_ready,
    input  wire [ffa_pkg::STATUS_W-1:0] status,
    input  wire [ffa_pkg::VAL_W-1:0]    result_value,
    output int                          fault_count,
    output int                          pending
);
    import ffa_pkg::*;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [VAL_W-1:0]    value;
    } outcome_t;

    localparam int NULL_LINK = ARENA_BYTES;

    // mirror of the header store, indexed by header byte offset
    int       block_size [ARENA_BYTES];
    int       block_link [ARENA_BYTES];
    int       free_head      = NULL_LINK;
    bit       arena_laid_out = 1'b0;
    outcome_t awaited [$];
    int       faults   = 0;
    int       reported = 0;

    function automatic void relink(input int prev, input int target);
        if (prev == NULL_LINK)
            free_head = target;
        else
            block_link[prev] = target;
    endfunction

    // returns 0 when the transaction produces no result
    function automatic bit compute_outcome(input logic [OP_W-1:0] op, input int req,
                                           input int rel, output outcome_t res);
        int cur;
        int prev;
        int steps;
        int c;
        int sz;
        int tail;
        int total;
        int hdr;
        res = '0;
        case (op)
            OP_ALLOC:
            begin
                if (req == 0)
                begin
                    res.status = STS_ZERO;
                    return 1'b1;
                end
                if (!arena_laid_out)
                begin
                    arena_laid_out = 1'b1;
                    free_head      = 0;
                    block_size[0]  = ARENA_BYTES - HEADER_BYTES;
                    block_link[0]  = NULL_LINK;
                end
                prev  = NULL_LINK;
                cur   = free_head;
                steps = 0;
                while (cur != NULL_LINK && steps < ARENA_BYTES)
                begin
                    c  = cur % ARENA_BYTES;
                    sz = block_size[c];
                    if (sz >= req)
                    begin
                        if (sz - req > HEADER_BYTES)
                        begin
                            // split, the tail header may wrap round the arena
                            tail             = (c + HEADER_BYTES + req) % ARENA_BYTES;
                            block_size[tail] = sz - req - HEADER_BYTES;
                            block_link[tail] = block_link[c];
                            block_size[c]    = req;
                            relink(prev, tail);
                        end
                        else
                        begin
                            relink(prev, block_link[c]);
                        end
                        block_link[c] = NULL_LINK;
                        res.status    = STS_ALLOC;
                        res.value     = VAL_W'(c + HEADER_BYTES);
                        return 1'b1;
                    end
                    prev = c;
                    cur  = block_link[c];
                    steps++;
                end
                res.status = STS_NO_FIT;
            end
            OP_FREE:
            begin
                if (rel < HEADER_BYTES)
                begin
                    res.status = STS_NULL_FREE;
                    return 1'b1;
                end
                hdr = rel - HEADER_BYTES;
                if (hdr >= ARENA_BYTES)
                begin
                    res.status = STS_NULL_FREE;
                    return 1'b1;
                end
                block_link[hdr] = free_head;
                free_head       = hdr;
                res.status      = STS_FREED;
            end
            OP_QUERY:
            begin
                total = 0;
                cur   = free_head;
                steps = 0;
                while (cur != NULL_LINK && steps < ARENA_BYTES)
                begin
                    c  = cur % ARENA_BYTES;
                    sz = block_size[c];
                    if (sz > int'(SUM_MAX) - total)
                        total = int'(SUM_MAX);
                    else
                        total = total + sz;
                    cur = block_link[c];
                    steps++;
                end
                res.status = STS_QUERY;
                res.value  = VAL_W'(total);
            end
            default: return 1'b0;
        endcase
        return 1'b1;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        outcome_t want;
        outcome_t got;
        if (!rst_n)
        begin
            awaited.delete();
            free_head      = NULL_LINK;
            arena_laid_out = 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                if (compute_outcome(opcode, int'(request_bytes), int'(release_offset), want))
                    awaited.push_back(want);
            end
            if (out_valid && out_ready)
            begin
                got.status = status;
                got.value  = result_value;
                if (awaited.size() == 0)
                begin
                    faults++;
                    if (reported < 10)
                        $display("unexpected result: status %0d value %0d", status, result_value);
                    reported++;
                end
                else
                begin
                    want = awaited.pop_front();
                    if (got !== want)
                    begin
                        faults++;
                        if (reported < 10)
                            $display("mismatch: status exp %0d got %0d, value exp %0d got %0d",
                                     want.status, got.status, want.value, got.value);
                        reported++;
                    end
                end
            end
        end
        fault_count <= faults;
        pending     <= awaited.size();
    end

endmodule

// ===== tb/sv/first_fit_free_list_allocator_test.sv =====
`timescale 1ns / 1ps
// top of the allocator testbench: clock, reset, stimulus, receiver back-pressure and verdict
// depends on ffa_pkg, first_fit_free_list_allocator and ffa_result_checker
module first_fit_free_list_allocator_test;

    import ffa_pkg::*;

    // a walk round a cyclic list visits ARENA_BYTES headers; the stall limit lies well above that
    localparam int STALL_LIMIT   = 40000;
    localparam int SETTLE_CYCLES = 20;
    localparam int PHASE_ITEMS   = 450;

    // geometry of the directed part, worked out from a freshly laid-out arena
    localparam int FULL_PAYLOAD   = ARENA_BYTES_DEF - HEADER_BYTES_DEF;
    localparam int REST_PAYLOAD   = FULL_PAYLOAD - 1 - HEADER_BYTES_DEF;
    localparam int FIRST_PAYLOAD  = HEADER_BYTES_DEF;
    localparam int SECOND_PAYLOAD = 2 * HEADER_BYTES_DEF + 1;

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                out_ready;
    logic [OP_W-1:0]     opcode;
    logic [REQ_W-1:0]    request_bytes;
    logic [REL_W-1:0]    release_offset;
    wire                 in_ready;
    wire                 out_valid;
    wire [STATUS_W-1:0]  status;
    wire [VAL_W-1:0]     result_value;

    int fault_count;
    int pending;
    int idle_cycles = 0;
    bit steady      = 1'b0;

    // payload offsets handed out and not yet given back; random frees of real blocks pick only these
    int live_blocks [$];
    bit last_was_alloc = 1'b0;
    int last_offset    = 0;

    first_fit_free_list_allocator i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .opcode         (opcode),
        .request_bytes  (request_bytes),
        .release_offset (release_offset),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .status         (status),
        .result_value   (result_value)
    );

    ffa_result_checker i_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .opcode         (opcode),
        .request_bytes  (request_bytes),
        .release_offset (release_offset),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .status         (status),
        .result_value   (result_value),
        .fault_count    (fault_count),
        .pending        (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // idle length: none while steady, else mostly none, often a short gap, now and then a long stretch
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(4, 40);
    endfunction

    // payload sizes lean small so the list fragments into many short blocks
    function automatic int pick_size();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(1, 64);
        if (r < 90)
            return $urandom_range(65, 512);
        if (r < 98)
            return $urandom_range(513, 2048);
        return $urandom_range(2049, ARENA_BYTES_DEF);
    endfunction

    // receiver side: ready for a run of cycles, then perhaps a stall
    initial
    begin
        int stall;
        out_ready = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            out_ready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge clk);
            stall = pick_gap();
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
        end
    end

    // note every granted block so that frees of real blocks target headers that were handed out
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            last_was_alloc <= (status == STS_ALLOC);
            if (status == STS_ALLOC)
            begin
                live_blocks.push_back(int'(result_value));
                last_offset <= int'(result_value);
            end
        end
    end

    // watchdog: any stretch with no transaction on either channel that runs too long
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else if (idle_cycles == STALL_LIMIT)
        begin
            $display("first_fit_free_list_allocator test failed");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // present one transaction, hold it until taken, then maybe leave a gap
    task automatic send_item(input logic [OP_W-1:0] op, input int req, input int rel);
        int gap;
        in_valid       <= 1'b1;
        opcode         <= op;
        request_bytes  <= REQ_W'(req);
        release_offset <= REL_W'(rel);
        do
            @(posedge clk);
        while (!in_ready);
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // hold off the sender until every outstanding result has come back
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    // free a known block; waiting first makes sure its grant has been seen
    task automatic release_block(input int off);
        drain();
        for (int i = 0; i < live_blocks.size(); i++)
        begin
            if (live_blocks[i] == off)
            begin
                live_blocks.delete(i);
                break;
            end
        end
        send_item(OP_FREE, $urandom, off);
    endtask

    // one random transaction; counted is low when the block just ignores it
    task automatic random_item(output bit counted);
        int pick;
        int idx;
        int off;
        int junk_req;
        int junk_rel;
        pick     = $urandom_range(0, 99);
        junk_req = $urandom_range(0, (1 << REQ_W) - 1);
        junk_rel = $urandom_range(0, (1 << REL_W) - 1);
        counted  = 1'b1;
        // with many blocks held, lean towards giving some back
        if (live_blocks.size() > 64)
            pick = $urandom_range(44, 99);
        if (pick < 44 || (pick < 80 && live_blocks.size() == 0))
            send_item(OP_ALLOC, pick_size(), junk_rel);
        else if (pick < 80)
        begin
            idx = $urandom_range(0, live_blocks.size() - 1);
            off = live_blocks[idx];
            live_blocks.delete(idx);
            send_item(OP_FREE, junk_req, off);
        end
        else if (pick < 90)
            send_item(OP_QUERY, junk_req, junk_rel);
        else
        begin
            // noise: zero size, null frees, the unused opcode, oversized requests
            case (pick % 4)
                0: send_item(OP_ALLOC, 0, junk_rel);
                1: send_item(OP_FREE, junk_req, $urandom_range(0, HEADER_BYTES_DEF - 1));
                2:
                begin
                    send_item(OP_NONE, junk_req, junk_rel);
                    counted = 1'b0;
                end
                default: send_item(OP_ALLOC, $urandom_range(ARENA_BYTES_DEF, (1 << REQ_W) - 1),
                                   junk_rel);
            endcase
        end
    endtask

    initial
    begin
        bit counted;
        int produced;
        int victim;
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        opcode         = OP_NONE;
        request_bytes  = '0;
        release_offset = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // before the arena is laid out: empty query, null frees, zero size, unused opcode
        send_item(OP_QUERY, 0, 0);
        send_item(OP_FREE, 0, 0);
        send_item(OP_FREE, 0, HEADER_BYTES_DEF - 1);
        send_item(OP_ALLOC, 0, 0);
        send_item(OP_NONE, (1 << REQ_W) - 1, (1 << REL_W) - 1);
        // frees before the first allocate are pushed, then thrown away by the layout
        send_item(OP_FREE, 0, 100);
        send_item(OP_FREE, 0, (1 << REL_W) - 1);

        // first allocate lays out the arena and splits off a one-byte block
        send_item(OP_ALLOC, 1, 0);
        send_item(OP_QUERY, 0, 0);
        send_item(OP_ALLOC, ARENA_BYTES_DEF, 0);
        // take the whole remaining block, leaving the list empty
        send_item(OP_ALLOC, REST_PAYLOAD, 0);
        send_item(OP_QUERY, 0, 0);
        send_item(OP_ALLOC, 5, 0);
        release_block(SECOND_PAYLOAD);
        release_block(FIRST_PAYLOAD);
        // remainder of exactly one header: whole block taken from behind the head
        send_item(OP_ALLOC, REST_PAYLOAD - HEADER_BYTES_DEF, 0);
        send_item(OP_QUERY, 0, 0);
        release_block(SECOND_PAYLOAD);
        // remainder one byte over a header: split with a one-byte tail
        send_item(OP_ALLOC, REST_PAYLOAD - HEADER_BYTES_DEF - 1, 0);
        send_item(OP_ALLOC, (1 << REQ_W) - 1, 0);
        send_item(OP_QUERY, 0, 0);
        drain();

        // random phases; the third one runs with no idling on either side
        for (int phase = 0; phase < 4; phase++)
        begin
            steady   = (phase == 2);
            produced = 0;
            while (produced < PHASE_ITEMS)
            begin
                random_item(counted);
                produced += counted;
            end
            drain();
        end
        steady = 1'b0;

        // closing phase: a double free turns the list into a loop onto itself,
        // so walks hit the step bound and the query sum saturates
        send_item(OP_ALLOC, 2, 0);
        drain();
        if (last_was_alloc)
        begin
            victim = last_offset;
            release_block(victim);
            release_block(victim);
            send_item(OP_QUERY, 0, 0);
            send_item(OP_ALLOC, ARENA_BYTES_DEF, 0);
            send_item(OP_QUERY, 0, 0);
            send_item(OP_ALLOC, 1, 0);
            send_item(OP_QUERY, 0, 0);
        end

        drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (fault_count == 0 && pending == 0)
            $display("first_fit_free_list_allocator test passed");
        else
            $display("first_fit_free_list_allocator test failed");
        $finish;
    end

endmodule
